/* hdl/mgrt_pkg.sv */
// shared constants and types for the minimum gap and range tracker
package mgrt_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [DATA_W-1:0] GAP_RESET = '1;

  localparam logic STATUS_STORED   = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // write port of the value store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } store_wr_t;

  // read port of the value store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } store_rd_t;

endpackage

/* hdl/mgrt_store.sv */
// value store: one write port, one registered read port
module mgrt_store (
  input  logic                         clk,
  input  mgrt_pkg::store_wr_t          wr,
  input  mgrt_pkg::store_rd_t          rd,
  output logic [mgrt_pkg::DATA_W-1:0]  rd_data
);
  import mgrt_pkg::*;

  logic [DATA_W-1:0] mem_r [MAX_ENTRIES];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/mgrt_dist.sv */
// shared distance unit: unsigned magnitude of the difference of two signed words
module mgrt_dist (
  input  logic signed [mgrt_pkg::DATA_W-1:0] op_a,
  input  logic signed [mgrt_pkg::DATA_W-1:0] op_b,
  output logic        [mgrt_pkg::DATA_W-1:0] mag
);
  import mgrt_pkg::*;

  logic signed [DATA_W:0] diff;

  always_comb begin
    diff = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
    // magnitude always fits in DATA_W bits
    if (diff[DATA_W]) begin
      mag = DATA_W'(-diff);
    end else begin
      mag = diff[DATA_W-1:0];
    end
  end

endmodule

/* hdl/min_gap_and_range_tracker.sv */
// top level: sequencer that scans the value store through one distance unit
//
// usage
//   input: drive in_value and pulse start while busy is low; the word is
//     taken at that edge and busy stays high until the result is out.
//   result: out_valid is high for exactly one cycle with out_status,
//     out_stored_count, out_spans_valid, out_shortest_span, out_longest_span.
//     the receiver cannot stall; the result must be taken in that cycle.
//   config: cfg_capacity is written when cfg_valid and cfg_ready are high;
//     cfg_ready is always high. write it only while the block is idle.
// timing
//   a stored word with n values already held walks the store one entry a
//     cycle through the single distance unit, then passes the update and
//     report states; no new word is taken before then, and start can be
//     taken again while out_valid is high.
//   a rejected word goes from idle straight to the report state. the store
//     read port and the shared distance unit set this pace.
// reset
//   rst_n low clears the count, range and gap state and sets capacity to 64;
//   store contents are left as they are and are only read below the count.
module min_gap_and_range_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  output logic                         out_status,
  output logic [6:0]                   out_stored_count,
  output logic                         out_spans_valid,
  output logic [31:0]                  out_shortest_span,
  output logic [31:0]                  out_longest_span,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [6:0]                   cfg_capacity
);
  import mgrt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_UPDATE = 4'b0100,
    ST_REPORT = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CAP_W-1:0]          capacity_r, capacity_nxt;
  logic [CNT_W-1:0]          held_r, held_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic signed [DATA_W-1:0]  value_r, value_nxt;
  logic signed [DATA_W-1:0]  smallest_r, smallest_nxt;
  logic signed [DATA_W-1:0]  largest_r, largest_nxt;
  logic [DATA_W-1:0]         gap_r, gap_nxt;
  logic                      status_r, status_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic                      out_status_r, out_status_nxt;
  logic [6:0]                out_count_r, out_count_nxt;
  logic                      out_spans_r, out_spans_nxt;
  logic [DATA_W-1:0]         out_short_r, out_short_nxt;
  logic [DATA_W-1:0]         out_long_r, out_long_nxt;

  store_wr_t                 st_wr;
  store_rd_t                 st_rd;
  logic [DATA_W-1:0]         st_rd_data;

  logic signed [DATA_W-1:0]  dist_a, dist_b;
  logic [DATA_W-1:0]         dist_mag;

  logic                      accept;
  logic                      full;
  logic                      two_held;

  mgrt_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (st_rd_data)
  );

  mgrt_dist u_dist (
    .op_a (dist_a),
    .op_b (dist_b),
    .mag  (dist_mag)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign full      = (CMP_W'(held_r) >= CMP_W'(capacity_r)) ||
                     (CMP_W'(held_r) >= CMP_W'(MAX_ENTRIES));
  assign two_held  = (CMP_W'(held_r) >= CMP_W'(2));

  // one unit: scan distances while scanning, range span while reporting
  always_comb begin
    if (state_r == ST_REPORT) begin
      dist_a = largest_r;
      dist_b = smallest_r;
    end else begin
      dist_a = value_r;
      dist_b = st_rd_data;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    capacity_nxt   = capacity_r;
    held_nxt       = held_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    value_nxt      = value_r;
    smallest_nxt   = smallest_r;
    largest_nxt    = largest_r;
    gap_nxt        = gap_r;
    status_nxt     = status_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_spans_nxt  = out_spans_r;
    out_short_nxt  = out_short_r;
    out_long_nxt   = out_long_r;
    st_wr          = '0;
    st_rd          = '0;

    if (cfg_valid && cfg_ready) begin
      capacity_nxt = cfg_capacity;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          value_nxt = in_value;
          idx_nxt   = '0;
          if (full) begin
            status_nxt = STATUS_REJECTED;
            state_nxt  = ST_REPORT;
          end else begin
            status_nxt = STATUS_STORED;
            state_nxt  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx_r != held_r) begin
          st_rd.en   = 1'b1;
          st_rd.addr = idx_r[ADDR_W-1:0];
          idx_nxt    = idx_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end else begin
          state_nxt = ST_UPDATE;
        end
        // compare the word read in the previous cycle
        if (rd_vld_r && (dist_mag < gap_r)) begin
          gap_nxt = dist_mag;
        end
      end
      ST_UPDATE: begin
        st_wr.en   = 1'b1;
        st_wr.addr = held_r[ADDR_W-1:0];
        st_wr.data = value_r;
        if (held_r == '0) begin
          smallest_nxt = value_r;
          largest_nxt  = value_r;
        end else begin
          if (value_r < smallest_r) begin
            smallest_nxt = value_r;
          end
          if (value_r > largest_r) begin
            largest_nxt = value_r;
          end
        end
        held_nxt  = held_r + CNT_W'(1);
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_count_nxt  = 7'(held_r);
        out_spans_nxt  = two_held;
        out_short_nxt  = two_held ? gap_r : '0;
        out_long_nxt   = two_held ? dist_mag : '0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_RESET;
      held_r      <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      smallest_r  <= '0;
      largest_r   <= '0;
      gap_r       <= GAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      capacity_r  <= capacity_nxt;
      held_r      <= held_nxt;
      idx_r       <= idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      smallest_r  <= smallest_nxt;
      largest_r   <= largest_nxt;
      gap_r       <= gap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_spans_r  <= out_spans_nxt;
    out_short_r  <= out_short_nxt;
    out_long_r   <= out_long_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_stored_count  = out_count_r;
  assign out_spans_valid   = out_spans_r;
  assign out_shortest_span = out_short_r;
  assign out_longest_span  = out_long_r;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted word did not make the block busy");

  a_strobe_after_report : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(state_r == ST_REPORT))
    else $error("result strobe without a report step");

  a_spans_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_spans_valid == (out_stored_count >= 7'd2)))
    else $error("spans flag disagrees with count");

  a_stored_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_STORED) |-> (out_stored_count != 7'd0))
    else $error("stored word reported with empty store");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(held_r) <= CMP_W'(MAX_ENTRIES))
    else $error("held count beyond store depth");

endmodule

/* verif/min_gap_and_range_tracker_tb.sv */
// self-checking testbench for the minimum gap and range tracker
`timescale 1ns / 100ps

module min_gap_and_range_tracker_tb;
  import mgrt_pkg::*;

  localparam int RANDOM_WORDS   = 1000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct packed {
    logic              status;
    logic [6:0]        stored_count;
    logic              spans_valid;
    logic [DATA_W-1:0] shortest_span;
    logic [DATA_W-1:0] longest_span;
  } span_report_t;

  // mirror of the held set: count, range and nearest pair distance
  class span_ledger;
    logic [CAP_W-1:0]         capacity;
    logic signed [DATA_W-1:0] held[$];
    logic signed [DATA_W-1:0] lowest;
    logic signed [DATA_W-1:0] highest;
    logic [DATA_W-1:0]        best_gap;
    span_report_t             owed_reports[$];
    int                       errors;

    function new();
      capacity = CAP_RESET;
      lowest   = '0;
      highest  = '0;
      best_gap = GAP_RESET;
      errors   = 0;
    endfunction

    function logic [DATA_W-1:0] abs_gap(logic signed [DATA_W-1:0] a,
                                        logic signed [DATA_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d[DATA_W-1:0];
    endfunction

    function int owed();
      return owed_reports.size();
    endfunction

    function void note_value(logic signed [DATA_W-1:0] v);
      int           limit;
      span_report_t r;
      limit = (int'(capacity) < MAX_ENTRIES) ? int'(capacity) : MAX_ENTRIES;
      r.status = STATUS_REJECTED;
      if (held.size() < limit) begin
        r.status = STATUS_STORED;
        foreach (held[i]) begin
          if (abs_gap(v, held[i]) < best_gap) best_gap = abs_gap(v, held[i]);
        end
        if (held.size() == 0) begin
          lowest  = v;
          highest = v;
        end else begin
          if (v < lowest) lowest = v;
          if (v > highest) highest = v;
        end
        held.insert(held.size(), v);
      end
      r.stored_count  = 7'(held.size());
      r.spans_valid   = held.size() >= 2;
      r.shortest_span = r.spans_valid ? best_gap : '0;
      r.longest_span  = r.spans_valid ? abs_gap(highest, lowest) : '0;
      owed_reports.insert(owed_reports.size(), r);
    endfunction

    function void compare_field(string field, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_report(span_report_t got);
      span_report_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: result word with none outstanding, expected none actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("stored_count", 32'(want.stored_count), 32'(got.stored_count));
      compare_field("spans_valid", 32'(want.spans_valid), 32'(got.spans_valid));
      compare_field("shortest_span", want.shortest_span, got.shortest_span);
      compare_field("longest_span", want.longest_span, got.longest_span);
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n        = 1'b0;
  logic                     start        = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value     = '0;
  logic                     out_valid;
  logic                     out_status;
  logic [6:0]               out_stored_count;
  logic                     out_spans_valid;
  logic [DATA_W-1:0]        out_shortest_span;
  logic [DATA_W-1:0]        out_longest_span;
  logic                     cfg_valid    = 1'b0;
  logic                     cfg_ready;
  logic [CAP_W-1:0]         cfg_capacity = '0;

  span_ledger book;
  int         burst_left  = 0;
  int         words_sent  = 0;
  int         idle_cycles = 0;

  min_gap_and_range_tracker dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_stored_count  (out_stored_count),
    .out_spans_valid   (out_spans_valid),
    .out_shortest_span (out_shortest_span),
    .out_longest_span  (out_longest_span),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_capacity      (cfg_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result words and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        book.check_report({out_status, out_stored_count, out_spans_valid,
                           out_shortest_span, out_longest_span});
      end
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d words outstanding", $time, book.owed());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sender works in bursts; a gap lowers start for a random stretch
  task automatic send_value(input logic [DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                               : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_value <= v;
    start    <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_value(v);
    words_sent++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    start <= 1'b0;
    while (book.owed() != 0) @(posedge clk);
    cfg_capacity <= c;
    cfg_valid    <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.capacity = c;
    cfg_valid <= 1'b0;
  endtask

  // duplicates and extremes only late, so the gap does not collapse early
  function automatic logic [DATA_W-1:0] pick_value();
    int                r;
    int                n;
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] delta;
    r = $urandom_range(0, 99);
    n = book.held.size();
    if (r < 45 || n == 0) return $urandom;
    if (r < 55) begin
      if (n < 56) return $urandom;
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return '0;
        default: return '1;
      endcase
    end
    base = book.held[$urandom_range(0, n - 1)];
    if (r < 60 && n >= 56) return base;
    delta = $urandom >> $urandom_range(4, 31);
    if (delta == 0) delta = 1;
    return $urandom_range(0, 1) ? base + delta : base - delta;
  endfunction

  initial begin
    int               r;
    int               n;
    int               burst;
    logic [CAP_W-1:0] c;

    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity left at its reset value
    send_value(32'h8000_0000);
    // zero capacity and capacity below the count
    write_capacity('0);
    send_value('0);
    send_value(32'h7fff_ffff);
    write_capacity(CAP_W'(1));
    send_value('1);
    // widest possible distance, then a full store at its limit
    write_capacity(CAP_W'(2));
    send_value(32'h7fff_ffff);
    send_value('0);
    // above the entry count the limit is the entry count
    write_capacity('1);
    send_value('0);
    send_value(32'h4000_0000);
    write_capacity(CAP_W'(MAX_ENTRIES));
    send_value(32'hc000_0000);

    while (words_sent < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      n = book.held.size();
      if (r < 55)      c = CAP_W'(n + $urandom_range(1, 4));
      else if (r < 63) c = CAP_W'($urandom_range(0, 127));
      else if (r < 75) c = '0;
      else if (r < 87) c = CAP_W'(n);
      else             c = (n > 0) ? CAP_W'($urandom_range(0, n - 1)) : '0;
      write_capacity(c);
      burst = $urandom_range(10, 50);
      repeat (burst) send_value(pick_value());
    end

    // fill to the last entry, then run into the full store
    write_capacity('1);
    while (book.held.size() < MAX_ENTRIES) send_value(pick_value());
    repeat (8) send_value(pick_value());

    start <= 1'b0;
    while (book.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
